>>> rtl/core/vector_to_pitch_yaw_defines.svh
// ----------------------------------------------------------------------------
// vector_to_pitch_yaw assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TO_PITCH_YAW_DEFINES_SVH
`define VECTOR_TO_PITCH_YAW_DEFINES_SVH

// Same-cycle implication.
`define V2PY_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define V2PY_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/v2py_pkg.sv
// ----------------------------------------------------------------------------
// v2py_pkg
// Types, constants and CORDIC helpers for the direction to pitch/yaw block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package v2py_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEPS        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  // Stage map: input capture, first pass, gain/yaw stage, second pass, output.
  localparam int ST_P1      = 1;
  localparam int ST_MID     = STEPS + 1;
  localparam int ST_P2      = STEPS + 2;
  localparam int ST_OUT     = 2 * STEPS + 2;
  localparam int NUM_STAGES = 2 * STEPS + 3;

  localparam int CW = 36;  // CORDIC x/y datapath width
  localparam int AW = 33;  // angle accumulator width, 2^-30 rad units

  localparam int HALF_PI    = 12868;
  localparam int PI_OUT     = 25736;
  localparam int THREE_HALF = 38604;
  localparam int GAIN_Q16   = 107922;
  localparam int ROUND_HALF = 65536;

  localparam logic [30:0] ATAN_TAB [TABLE_LEN] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
    31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
    31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
    31'd262143,    31'd131071,    31'd65535,     31'd32767,
    31'd16383,     31'd8191,      31'd4095,      31'd2047,
    31'd1023,      31'd511,       31'd255,       31'd127
  };

  typedef logic signed [CW-1:0] cword_t;
  typedef logic signed [AW-1:0] angle_t;

  typedef struct packed {
    cword_t x;
    cword_t y;
    angle_t a;
  } cordic_t;

  // Side data carried next to the CORDIC word.
  typedef struct packed {
    logic               yneg;
    logic               ypos;
    logic               xneg;
    logic               zneg;
    logic               zzero;
    logic               vert;
    logic               nohoriz;
    logic        [16:0] ay;
    logic signed [16:0] yaw;
  } side_t;

  // One vectoring rotation at a fixed shift.
  function automatic cordic_t cordic_iter(cordic_t c, int unsigned i);
    cordic_t r;
    cword_t  dx;
    cword_t  dy;
    angle_t  t;
    dx = c.y >>> i;
    dy = c.x >>> i;
    t  = angle_t'({{(AW-31){1'b0}}, ATAN_TAB[i]});
    if (c.y >= 0) begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.a = c.a + t;
    end else begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.a = c.a - t;
    end
    return r;
  endfunction

  // Round to 1/8192 rad and clamp to [0, pi/2].
  function automatic logic [13:0] to_out_clamp(angle_t a);
    logic signed [AW:0]  s;
    logic signed [AW-17:0] q;
    s = {a[AW-1], a} + $signed((AW+1)'(ROUND_HALF));
    q = s[AW:17];
    if (q < 0) begin
      return 14'd0;
    end else if (q > $signed((AW-16)'(HALF_PI))) begin
      return 14'(HALF_PI);
    end else begin
      return q[13:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/vector_to_pitch_yaw.sv
// ----------------------------------------------------------------------------
// vector_to_pitch_yaw
// Q2.14 direction vector to pitch and yaw angles via two CORDIC passes.
// ----------------------------------------------------------------------------
// Takes one vector per cycle while in_stall_o is low and returns pitch and
// yaw in rad*8192 through one capture stage, one register per rotation of
// the unrolled horizontal pass, a gain multiply stage, one register per
// rotation of the pitch pass and an output register. Each stage holds only
// while everything behind it is full, so bubbles close up under a stalled
// output and the input keeps taking words while a result waits.
`timescale 1ns / 1ps
`default_nettype none

`include "vector_to_pitch_yaw_defines.svh"

module vector_to_pitch_yaw (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [15:0] dir_x_i,
  input  wire logic signed [15:0] dir_y_i,
  input  wire logic signed [15:0] dir_z_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [14:0] pitch_angle_o,
  output      logic signed [16:0] yaw_angle_o
);

  localparam int N  = v2py_pkg::STEPS;
  localparam int NS = v2py_pkg::NUM_STAGES;

  logic [NS-1:0] valid_q;
  logic [NS-1:0] en;

  // Stage advance: a stage loads when empty or when the next one moves.
  always_comb begin
    en[NS-1] = !valid_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Capture stage: magnitudes and case flags.
  logic signed [16:0] xe, ye, ze;
  logic        [16:0] ax_d, ay_d, az_d;
  logic        [16:0] ax_q, az_q;
  v2py_pkg::side_t    s0_d, s0_q;

  always_comb begin
    xe   = {dir_x_i[15], dir_x_i};
    ye   = {dir_y_i[15], dir_y_i};
    ze   = {dir_z_i[15], dir_z_i};
    ax_d = (xe < 0) ? 17'(-xe) : 17'(xe);
    ay_d = (ye < 0) ? 17'(-ye) : 17'(ye);
    az_d = (ze < 0) ? 17'(-ze) : 17'(ze);
    s0_d.yneg    = dir_y_i[15];
    s0_d.ypos    = !dir_y_i[15] && (dir_y_i != 16'sd0);
    s0_d.xneg    = dir_x_i[15];
    s0_d.zneg    = dir_z_i[15];
    s0_d.zzero   = (dir_z_i == 16'sd0);
    s0_d.vert    = (dir_y_i == 16'sh4000) || (dir_y_i == 16'shC000);
    s0_d.nohoriz = (dir_x_i == 16'sd0) && (dir_z_i == 16'sd0);
    s0_d.ay      = ay_d;
    s0_d.yaw     = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ax_q <= ax_d;
      az_q <= az_d;
      s0_q <= s0_d;
    end
  end

  // Horizontal pass on (|z|, |x|).
  v2py_pkg::cordic_t p1_q [N];
  v2py_pkg::side_t   s1_q [N];
  v2py_pkg::cordic_t p1_init;

  always_comb begin
    p1_init.x = {{(v2py_pkg::CW-31){1'b0}}, az_q, 14'b0};
    p1_init.y = {{(v2py_pkg::CW-31){1'b0}}, ax_q, 14'b0};
    p1_init.a = '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_p1
    v2py_pkg::cordic_t src;
    v2py_pkg::side_t   side;
    v2py_pkg::cordic_t p1_d;
    if (k == 0) begin : g_first
      assign src  = p1_init;
      assign side = s0_q;
    end else begin : g_next
      assign src  = p1_q[k-1];
      assign side = s1_q[k-1];
    end
    assign p1_d = v2py_pkg::cordic_iter(src, k);
    always_ff @(posedge clk_i) begin
      if (en[v2py_pkg::ST_P1+k]) begin
        p1_q[k] <= p1_d;
        s1_q[k] <= side;
      end
    end
  end

  // Gain stage: scale |y| and settle yaw.
  logic        [33:0] prod;
  logic        [33:0] psum;
  logic        [13:0] amag;
  logic signed [16:0] aa;
  v2py_pkg::cordic_t  mid_d, mid_q;
  v2py_pkg::side_t    sm_d, sm_q;

  always_comb begin
    prod    = 34'(s1_q[N-1].ay) * 34'(v2py_pkg::GAIN_Q16);
    psum    = prod + 34'd2;
    mid_d.x = p1_q[N-1].x;
    mid_d.y = {{(v2py_pkg::CW-32){1'b0}}, psum[33:2]};
    mid_d.a = '0;
    amag    = s1_q[N-1].zzero ? 14'(v2py_pkg::HALF_PI)
                              : v2py_pkg::to_out_clamp(p1_q[N-1].a);
    aa      = {3'b0, amag};
    if (s1_q[N-1].xneg) aa = -aa;
    sm_d     = s1_q[N-1];
    sm_d.yaw = s1_q[N-1].zneg ? -aa : aa + 17'(v2py_pkg::PI_OUT);
  end

  always_ff @(posedge clk_i) begin
    if (en[v2py_pkg::ST_MID]) begin
      mid_q <= mid_d;
      sm_q  <= sm_d;
    end
  end

  // Pitch pass on (horizontal length, scaled |y|).
  v2py_pkg::cordic_t p2_q [N];
  v2py_pkg::side_t   s2_q [N];

  for (genvar k = 0; k < N; k++) begin : g_p2
    v2py_pkg::cordic_t src;
    v2py_pkg::side_t   side;
    v2py_pkg::cordic_t p2_d;
    if (k == 0) begin : g_first
      assign src  = mid_q;
      assign side = sm_q;
    end else begin : g_next
      assign src  = p2_q[k-1];
      assign side = s2_q[k-1];
    end
    assign p2_d = v2py_pkg::cordic_iter(src, k);
    always_ff @(posedge clk_i) begin
      if (en[v2py_pkg::ST_P2+k]) begin
        p2_q[k] <= p2_d;
        s2_q[k] <= side;
      end
    end
  end

  // Output stage: sign the pitch, override the degenerate cases.
  logic        [13:0] pmag;
  logic signed [14:0] pn;
  logic signed [14:0] pitch_d, pitch_q;
  logic signed [16:0] yaw_d, yaw_q;
  v2py_pkg::side_t    so;

  always_comb begin
    so   = s2_q[N-1];
    pmag = v2py_pkg::to_out_clamp(p2_q[N-1].a);
    pn   = {1'b0, pmag};
    if (so.vert || so.nohoriz) begin
      yaw_d = '0;
      if (so.ypos) begin
        pitch_d = 15'(v2py_pkg::HALF_PI);
      end else if (so.yneg) begin
        pitch_d = -15'(v2py_pkg::HALF_PI);
      end else begin
        pitch_d = '0;
      end
    end else begin
      yaw_d   = so.yaw;
      pitch_d = so.yneg ? -pn : pn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[v2py_pkg::ST_OUT]) begin
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
    end
  end

  assign out_valid_o   = valid_q[NS-1];
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

  logic out_in_range;

  assign out_in_range = (yaw_angle_o >= -17'sd12868) && (yaw_angle_o <= 17'sd38604) &&
                        (pitch_angle_o >= -15'sd12868) && (pitch_angle_o <= 15'sd12868);

  `V2PY_ASSERT_NOW(a_stall_full, in_stall_o, (&valid_q) && out_stall_i, "stall with room")
  `V2PY_ASSERT_NEXT(a_accept_lands, in_valid_i && !in_stall_o, valid_q[0], "word lost")
  `V2PY_ASSERT_NOW(a_out_range, out_valid_o, out_in_range, "result out of range")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_to_pitch_yaw testbench
// Streams direction vectors through the block under bursty input and a
// stalling output. Every accepted word gets its expected angles, either
// typed into the directed table or computed by a local two-pass CORDIC
// model. Results are compared in order, field by field.
// ----------------------------------------------------------------------------

module testbench;

  localparam int PIPE_DEPTH   = 2 * v2py_pkg::STEPS + 3;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic signed [14:0] pitch;
    logic signed [16:0] yaw;
  } angles_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bit                 typed;
    int                 pitch;
    int                 yaw;
  } vector_row_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] dir_x_i     = '0;
  logic signed [15:0] dir_y_i     = '0;
  logic signed [15:0] dir_z_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [14:0] pitch_angle_o;
  logic signed [16:0] yaw_angle_o;

  // Expectation riding along with the word being offered.
  bit                 word_typed  = 1'b0;
  int                 word_pitch  = 0;
  int                 word_yaw    = 0;

  angles_t            expected_angles [$];
  int                 mismatch_count = 0;
  bit                 hold_request   = 1'b0;
  vector_row_t        directed_rows [24];

  vector_to_pitch_yaw uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .dir_x_i       (dir_x_i),
    .dir_y_i       (dir_y_i),
    .dir_z_i       (dir_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pitch_angle_o (pitch_angle_o),
    .yaw_angle_o   (yaw_angle_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Round 2^-30 rad to 1/8192 rad, half up.
  function automatic longint round_to_out(longint a);
    return (a + v2py_pkg::ROUND_HALF) >>> 17;
  endfunction

  function automatic void cordic_vectoring(input longint x0, input longint y0,
                                           output longint mag, output longint ang);
    longint cx;
    longint cy;
    longint acc;
    longint sx;
    longint sy;
    cx  = x0;
    cy  = y0;
    acc = 0;
    for (int i = 0; i < v2py_pkg::STEPS; i++) begin
      sx = cy >>> i;
      sy = cx >>> i;
      if (cy >= 0) begin
        cx  = cx + sx;
        cy  = cy - sy;
        acc = acc + longint'(v2py_pkg::ATAN_TAB[i]);
      end else begin
        cx  = cx - sx;
        cy  = cy + sy;
        acc = acc - longint'(v2py_pkg::ATAN_TAB[i]);
      end
    end
    mag = cx;
    ang = acc;
  endfunction

  function automatic angles_t predict_angles(logic signed [15:0] x, logic signed [15:0] y,
                                             logic signed [15:0] z);
    angles_t r;
    longint  vx;
    longint  vy;
    longint  vz;
    longint  pitch;
    longint  yaw;
    longint  hmag;
    longint  hang;
    longint  pmag;
    longint  pang;
    longint  a;
    longint  p;
    longint  ys;
    vx = x;
    vy = y;
    vz = z;
    if (vy == 16384 || vy == -16384) begin
      pitch = (vy > 0) ? v2py_pkg::HALF_PI : -v2py_pkg::HALF_PI;
      yaw   = 0;
    end else if (vx == 0 && vz == 0) begin
      pitch = (vy > 0) ? v2py_pkg::HALF_PI : ((vy < 0) ? -v2py_pkg::HALF_PI : 0);
      yaw   = 0;
    end else begin
      cordic_vectoring(((vz < 0) ? -vz : vz) * 16384, ((vx < 0) ? -vx : vx) * 16384,
                       hmag, hang);
      a = (vz == 0) ? v2py_pkg::HALF_PI
                    : clamp_range(round_to_out(hang), 0, v2py_pkg::HALF_PI);
      if (vx < 0) a = -a;
      yaw = (vz < 0) ? -a : a + v2py_pkg::PI_OUT;
      // Pre-scale |y| by the CORDIC gain so both legs match.
      ys = (((vy < 0) ? -vy : vy) * v2py_pkg::GAIN_Q16 + 2) >>> 2;
      cordic_vectoring(hmag, ys, pmag, pang);
      p = clamp_range(round_to_out(pang), 0, v2py_pkg::HALF_PI);
      pitch = (vy < 0) ? -p : p;
    end
    pitch   = clamp_range(pitch, -v2py_pkg::HALF_PI, v2py_pkg::HALF_PI);
    yaw     = clamp_range(yaw, -v2py_pkg::HALF_PI, v2py_pkg::THREE_HALF);
    r.pitch = 15'(pitch);
    r.yaw   = 17'(yaw);
    return r;
  endfunction

  function automatic logic signed [15:0] random_component(bit axis_y);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (axis_y && pick < 5) begin
      return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
    end else if (pick < 75) begin
      return 16'($signed($urandom_range(0, 32768)) - 16384);
    end else if (pick < 85) begin
      case ($urandom_range(0, 4))
        0: return 16'sd0;
        1: return 16'sd1;
        2: return -16'sd1;
        3: return 16'sd16384;
        default: return -16'sd16384;
      endcase
    end else begin
      return 16'($urandom());
    end
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, bit typed, int p, int yw);
    in_valid_i <= 1'b1;
    dir_x_i    <= x;
    dir_y_i    <= y;
    dir_z_i    <= z;
    word_typed <= typed;
    word_pitch <= p;
    word_yaw   <= yw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_for_drain();
    @(posedge clk_i);
    while (expected_angles.size() != 0) @(posedge clk_i);
  endtask

  // Scoreboard: record accepted words, check accepted results.
  always @(posedge clk_i) begin
    angles_t want;
    angles_t pred;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (word_typed) begin
          pred.pitch = 15'(word_pitch);
          pred.yaw   = 17'(word_yaw);
        end else begin
          pred = predict_angles(dir_x_i, dir_y_i, dir_z_i);
        end
        expected_angles.push_back(pred);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected result pitch %0d yaw %0d", $time,
                   pitch_angle_o, yaw_angle_o);
          mismatch_count++;
        end else begin
          want = expected_angles.pop_front();
          if (pitch_angle_o !== want.pitch) begin
            $display("%0t: pitch mismatch expected %0d actual %0d", $time,
                     want.pitch, pitch_angle_o);
            mismatch_count++;
          end
          if (yaw_angle_o !== want.yaw) begin
            $display("%0t: yaw mismatch expected %0d actual %0d", $time,
                     want.yaw, yaw_angle_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Output backpressure: modes of varying density, plus one long hold-off.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned phase;
    mode  = 0;
    span  = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(50, 300);
        end
        span--;
        phase++;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= phase[2];
        endcase
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("vector_to_pitch_yaw test failed");
    $finish;
  end

  initial begin
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    int                 sent;
    int                 burst;
    int                 gap;
    directed_rows = '{
      // vertical nudge: x and z ignored
      '{16'sd0,      16'sd16384,  16'sd0,      1'b1,  12868,     0},
      '{16'sd0,     -16'sd16384,  16'sd0,      1'b1, -12868,     0},
      '{16'sd16384,  16'sd16384, -16'sd16384,  1'b1,  12868,     0},
      '{-16'sd32768,-16'sd16384,  16'sd32767,  1'b1, -12868,     0},
      // no horizontal part
      '{16'sd0,      16'sd0,      16'sd0,      1'b1,      0,     0},
      '{16'sd0,      16'sd100,    16'sd0,      1'b1,  12868,     0},
      '{16'sd0,     -16'sd1,      16'sd0,      1'b1, -12868,     0},
      '{16'sd0,      16'sd32767,  16'sd0,      1'b1,  12868,     0},
      '{16'sd0,     -16'sd32768,  16'sd0,      1'b1, -12868,     0},
      // zero z, pitch from the second pass
      '{16'sd16384,  16'sd0,      16'sd0,      1'b0,      0,     0},
      '{-16'sd16384, 16'sd0,      16'sd0,      1'b0,      0,     0},
      '{16'sd1,      16'sd5000,   16'sd0,      1'b0,      0,     0},
      '{-16'sd1,    -16'sd5000,   16'sd0,      1'b0,      0,     0},
      // pure z and horizontal diagonals, both signs
      '{16'sd0,      16'sd0,     -16'sd16384,  1'b0,      0,     0},
      '{16'sd0,      16'sd0,      16'sd16384,  1'b0,      0,     0},
      '{16'sd16384,  16'sd0,      16'sd16384,  1'b0,      0,     0},
      '{-16'sd16384, 16'sd0,     -16'sd16384,  1'b0,      0,     0},
      '{16'sd11585,  16'sd0,     -16'sd11585,  1'b0,      0,     0},
      // out-of-range magnitudes
      '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0,      0,     0},
      '{-16'sd32768,-16'sd32768, -16'sd32768,  1'b0,      0,     0},
      // near vertical, just off the nudge, then two off-axis vectors
      '{16'sd0,      16'sd16383,  16'sd1,      1'b0,      0,     0},
      '{16'sd0,     -16'sd16383, -16'sd1,      1'b0,      0,     0},
      '{16'sd9459,   16'sd9459,   16'sd9459,   1'b0,      0,     0},
      '{16'sd16384, -16'sd16383,  16'sd16384,  1'b0,      0,     0}
    };

    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_vector(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                  directed_rows[i].typed, directed_rows[i].pitch, directed_rows[i].yaw);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        rx = random_component(1'b0);
        ry = random_component(1'b1);
        rz = random_component(1'b0);
        if ($urandom_range(0, 29) == 0) begin
          rx = '0;
          rz = '0;
        end
        send_vector(rx, ry, rz, 1'b0, 0, 0);
        sent++;
        // Long receiver hold-off while words keep coming.
        if (sent == 400) hold_request = 1'b1;
        // Pause until the pipeline is empty.
        if (sent == 800) begin
          in_valid_i <= 1'b0;
          wait_for_drain();
        end
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    in_valid_i <= 1'b0;
    wait_for_drain();
    repeat (PIPE_DEPTH + 5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("vector_to_pitch_yaw test passed");
    end else begin
      $display("vector_to_pitch_yaw test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/v2py_pkg.sv
rtl/core/vector_to_pitch_yaw.sv
tb/testbench.sv
